>>> hdl/prrl_pkg.sv
package prrl_pkg;

  localparam int RELAYS     = 6;
  localparam int TIMER_BITS = 16;
  localparam int DRIVE_W    = 6;
  localparam int CFG_TIME_W = 16;
  localparam int CFG_CNT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IDX_W      = 3;

  typedef logic [TIMER_BITS-1:0] timer_t;

  localparam timer_t TIMER_MAX = '1;

  typedef enum logic [2:0] {
    FN_TICK   = 3'd0,
    FN_SET    = 3'd1,
    FN_FORCE  = 3'd2,
    FN_ON     = 3'd3,
    FN_OFF    = 3'd4,
    FN_TOGGLE = 3'd5,
    FN_GET    = 3'd6
  } func_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS  = 2'd2;

  localparam logic [CFG_CNT_W-1:0]  ACTIVE_RST = 3'd6;
  localparam logic [CFG_TIME_W-1:0] REPEAT_RST = 16'd1000;
  localparam logic [CFG_TIME_W-1:0] PRESS_RST  = 16'd100;

  // Command sent to each relay slice; only hit differs between slices.
  typedef struct packed {
    logic  tick;
    logic  hit;
    func_t func;
    logic  target;
  } rly_cmd_t;

  // Status returned by one relay slice.
  typedef struct packed {
    logic on;
    logic ok;
    logic pulse_nxt;
  } rly_stat_t;

endpackage

>>> hdl/prrl_relay.sv
module prrl_relay (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  prrl_pkg::rly_cmd_t                    cmd,
  input  logic [prrl_pkg::CFG_TIME_W-1:0]       repeat_time,
  input  logic [prrl_pkg::CFG_TIME_W-1:0]       press_time,
  output prrl_pkg::rly_stat_t                   stat
);

  logic             on_r, on_nxt;
  prrl_pkg::timer_t sp_r, sp_nxt;
  prrl_pkg::timer_t pl_r, pl_nxt;
  prrl_pkg::timer_t pl_dec;
  logic             want;
  logic             is_req;
  logic             can_pulse;
  logic             ok;

  always_comb begin
    want   = cmd.target;
    is_req = 1'b1;
    case (cmd.func)
      prrl_pkg::FN_SET:    want = cmd.target;
      prrl_pkg::FN_ON:     want = 1'b1;
      prrl_pkg::FN_OFF:    want = 1'b0;
      prrl_pkg::FN_TOGGLE: want = ~on_r;
      default:             is_req = 1'b0;
    endcase
  end

  assign can_pulse = 32'(sp_r) > 32'(repeat_time);
  assign pl_dec    = (pl_r != '0) ? pl_r - prrl_pkg::timer_t'(1) : pl_r;

  always_comb begin
    on_nxt = on_r;
    sp_nxt = sp_r;
    pl_nxt = pl_r;
    ok     = 1'b0;
    if (is_req) begin
      if (on_r == want) begin
        ok = 1'b1;
      end else if (can_pulse) begin
        ok = 1'b1;
        if (cmd.hit) begin
          pl_nxt = prrl_pkg::timer_t'(press_time);
          sp_nxt = '0;
          on_nxt = want;
        end
      end
    end else if (cmd.func == prrl_pkg::FN_FORCE) begin
      ok = 1'b1;
      if (cmd.hit) begin
        on_nxt = cmd.target;
      end
    end else if (cmd.func == prrl_pkg::FN_GET) begin
      ok = 1'b1;
    end
    // A tick first counts the pulse down, then ages the relay once it is idle.
    if (cmd.tick) begin
      pl_nxt = pl_dec;
      if (pl_dec == '0 && sp_r != prrl_pkg::TIMER_MAX) begin
        sp_nxt = sp_r + prrl_pkg::timer_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r <= 1'b0;
      sp_r <= '0;
      pl_r <= '0;
    end else begin
      on_r <= on_nxt;
      sp_r <= sp_nxt;
      pl_r <= pl_nxt;
    end
  end

  assign stat.on        = on_r;
  assign stat.ok        = ok;
  assign stat.pulse_nxt = (pl_nxt != '0);

endmodule

>>> hdl/pulse_relay_rate_limiter.sv
// Channel   | Direction | tdata (low bit up)                          | tuser
// in_*      | input     | relay_index[2:0], target_state, 4'b0        | func[2:0]
// out_*     | output    | ok, state_read, drive_lines[5:0]            | -
// cfg_*     | input     | write enable, register index, write data    | -
//
// An item is taken into an input register, evaluated against the relay state
// once the result register is free or draining, and written to the result register;
// one item per cycle while the output is not stalled.
// Synchronous active-low reset turns all relays off and clears all counters.
// A stalled result holds the input register, which then stalls the input side.
module pulse_relay_rate_limiter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,  // relay_index[2:0], target_state
  input  logic [2:0]                          in_tuser,  // func[2:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata, // ok, state_read, drive_lines[5:0]
  input  logic                                cfg_wr_en,
  input  logic [prrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [prrl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [prrl_pkg::CFG_CNT_W-1:0]  act_r;
  logic [prrl_pkg::CFG_TIME_W-1:0] rep_r;
  logic [prrl_pkg::CFG_TIME_W-1:0] prs_r;

  logic                            in_vld_r;
  prrl_pkg::func_t                 in_func_r;
  logic [prrl_pkg::IDX_W-1:0]      in_idx_r;
  logic                            in_tgt_r;

  logic                            out_vld_r;
  logic                            out_ok_r, ok_nxt;
  logic                            out_rd_r, rd_nxt;
  logic [prrl_pkg::DRIVE_W-1:0]    out_drv_r, drv_nxt;

  logic                            adv;
  logic                            idx_ok;
  logic                            sel_ok;
  logic                            sel_on;
  prrl_pkg::rly_cmd_t              cmd [prrl_pkg::RELAYS];
  prrl_pkg::rly_stat_t             stat [prrl_pkg::RELAYS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= prrl_pkg::ACTIVE_RST;
      rep_r <= prrl_pkg::REPEAT_RST;
      prs_r <= prrl_pkg::PRESS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        prrl_pkg::CFG_ACTIVE: act_r <= cfg_wdata[prrl_pkg::CFG_CNT_W-1:0];
        prrl_pkg::CFG_REPEAT: rep_r <= cfg_wdata[prrl_pkg::CFG_TIME_W-1:0];
        prrl_pkg::CFG_PRESS:  prs_r <= cfg_wdata[prrl_pkg::CFG_TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_func_r <= prrl_pkg::func_t'(in_tuser);
      in_idx_r  <= in_tdata[2:0];
      in_tgt_r  <= in_tdata[3];
    end
  end

  // An index must lie below both the configured count and the relay count.
  assign idx_ok = (32'(in_idx_r) < 32'(act_r)) && (32'(in_idx_r) < prrl_pkg::RELAYS);

  always_comb begin
    sel_ok = 1'b0;
    sel_on = 1'b0;
    for (int i = 0; i < prrl_pkg::RELAYS; i++) begin
      if (32'(in_idx_r) == i) begin
        sel_ok = stat[i].ok;
        sel_on = stat[i].on;
      end
    end
  end

  for (genvar g = 0; g < prrl_pkg::RELAYS; g++) begin : g_relay
    always_comb begin
      cmd[g].tick   = adv && (in_func_r == prrl_pkg::FN_TICK);
      cmd[g].hit    = adv && idx_ok && (32'(in_idx_r) == g);
      cmd[g].func   = in_func_r;
      cmd[g].target = in_tgt_r;
    end

    prrl_relay u_relay (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd[g]),
      .repeat_time (rep_r),
      .press_time  (prs_r),
      .stat        (stat[g])
    );
  end

  always_comb begin
    ok_nxt = 1'b0;
    rd_nxt = 1'b0;
    case (in_func_r)
      prrl_pkg::FN_TICK: ok_nxt = 1'b1;
      prrl_pkg::FN_SET, prrl_pkg::FN_FORCE, prrl_pkg::FN_ON,
      prrl_pkg::FN_OFF, prrl_pkg::FN_TOGGLE: ok_nxt = idx_ok && sel_ok;
      prrl_pkg::FN_GET: begin
        ok_nxt = idx_ok && sel_ok;
        rd_nxt = idx_ok && sel_on;
      end
      default: ;
    endcase
  end

  // Drive bits are active low and show the press pulse after this item; missing relays read high.
  always_comb begin
    drv_nxt = '1;
    for (int i = 0; i < prrl_pkg::DRIVE_W; i++) begin
      if (i < prrl_pkg::RELAYS) begin
        drv_nxt[i] = ~stat[i].pulse_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ok_r  <= ok_nxt;
      out_rd_r  <= rd_nxt;
      out_drv_r <= drv_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_drv_r, out_rd_r, out_ok_r};

  // A tick always reports success.
  a_tick_ok: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (in_func_r == prrl_pkg::FN_TICK) |=> out_tdata[0])
    else $error("tick result without ok");

  // Only a get can report a relay state.
  a_rd_get: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (in_func_r != prrl_pkg::FN_GET) |=> !out_tdata[1])
    else $error("state_read set for a command other than get");

  // A held input item keeps its command until it is evaluated.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(in_func_r) && $stable(in_idx_r))
    else $error("pending item lost or changed");

  // A result is produced only when the result register was free or drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_tready |-> !adv)
    else $error("result overwritten while stalled");

endmodule
